// ----- sv/rgbg_pkg.sv -----
// rgbg_pkg: shared types, register codes, constants and curve tables for the
// RGB gamma encoder. Tables are built at elaboration from the curve constants.
// No dependencies.
`default_nettype none

package rgbg_pkg;

  localparam int SampleW = 16;
  localparam int ExpW    = $clog2(SampleW);
  localparam int CfgIdxW = 1;
  localparam int NumStg  = 17;

  localparam logic [CfgIdxW-1:0] CfgWhitePoint = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgBlackLevel = 1'b1;

  // toe: floor(12.92f * k) == (k * ToeMul) >> 25 for k below ToeLimit
  localparam logic [SampleW-1:0] ToeLimit = SampleW'(200);
  localparam logic [28:0]        ToeMul   = 29'd433524140;

  // single-precision curve constants as integer numerators
  localparam longint      ExpNum = 13981025;      // p = ExpNum / 2^25
  localparam logic [23:0] FacNum = 24'd11150179;  // factor = FacNum / 2^14
  localparam logic [23:0] ConNum = 24'd14763725;  // offset = ConNum / 2^12

  localparam real ExpP = 13981025.0 / 33554432.0;

  // binomial series of (1+u)^p
  localparam real B2r = ExpP * (ExpP - 1.0) / 2.0;
  localparam real B3r = B2r * (ExpP - 2.0) / 3.0;
  localparam real B4r = B3r * (ExpP - 3.0) / 4.0;
  localparam real B5r = B4r * (ExpP - 4.0) / 5.0;
  localparam real B6r = B5r * (ExpP - 5.0) / 6.0;

  localparam logic [47:0]        CoefB1 = 48'(ExpNum << 23);   // Q0.48, exact
  localparam logic signed [33:0] CoefB2 = 34'(longint'(B2r * 4294967296.0));
  localparam logic signed [33:0] CoefB3 = 34'(longint'(B3r * 4294967296.0));
  localparam logic signed [33:0] CoefB4 = 34'(longint'(B4r * 4294967296.0));
  localparam logic signed [33:0] CoefB5 = 34'(longint'(B5r * 4294967296.0));
  localparam logic signed [33:0] CoefB6 = 34'(longint'(B6r * 4294967296.0));

  typedef struct packed {
    logic [SampleW-1:0] white_point;
    logic [SampleW-1:0] black_level;
  } cfg_t;

  typedef logic [47:0]     mant_tab_t [256];
  typedef logic [49:0]     rcp_tab_t  [256];
  typedef logic [47:0]     ef_tab_t   [SampleW];
  typedef logic [2:0]      ei_tab_t   [SampleW];

  // (1 + j/256)^p, Q1.47
  function automatic mant_tab_t mant_tab_f();
    mant_tab_t res;
    for (int j = 0; j < 256; j++) begin
      res[j] = 48'(longint'($pow(1.0 + real'(j) / 256.0, ExpP) * 140737488355328.0));
    end
    return res;
  endfunction

  // 2^57 / (256 + j), so that u = w * rcp / 2^64
  function automatic rcp_tab_t rcp_tab_f();
    rcp_tab_t res;
    for (int j = 0; j < 256; j++) begin
      res[j] = 50'(longint'($pow(256.0 + real'(j), -1.0) * 144115188075855872.0));
    end
    return res;
  endfunction

  // 2^frac(e*p), Q1.47
  function automatic ef_tab_t ef_tab_f();
    ef_tab_t res;
    longint  n_v;
    real     fr_v;
    for (int e = 0; e < SampleW; e++) begin
      n_v    = longint'(e) * ExpNum;
      fr_v   = real'(n_v & 64'd33554431) / 33554432.0;
      res[e] = 48'(longint'($pow(2.0, fr_v) * 140737488355328.0));
    end
    return res;
  endfunction

  // floor(e*p)
  function automatic ei_tab_t ei_tab_f();
    ei_tab_t res;
    longint  n_v;
    for (int e = 0; e < SampleW; e++) begin
      n_v    = longint'(e) * ExpNum;
      res[e] = 3'(n_v >> 25);
    end
    return res;
  endfunction

  localparam mant_tab_t MantTab = mant_tab_f();
  localparam rcp_tab_t  RcpTab  = rcp_tab_f();
  localparam ef_tab_t   EfTab   = ef_tab_f();
  localparam ei_tab_t   EiTab   = ei_tab_f();

endpackage

`default_nettype wire

// ----- sv/rgbg_in_if.sv -----
// rgbg_in_if: valid/ready channel carrying one linear RGB word.
// Depends on rgbg_pkg.
`default_nettype none

interface rgbg_in_if;
  logic                         valid;
  logic                         ready;
  logic [rgbg_pkg::SampleW-1:0] red_in;
  logic [rgbg_pkg::SampleW-1:0] green_in;
  logic [rgbg_pkg::SampleW-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

`default_nettype wire

// ----- sv/rgbg_out_if.sv -----
// rgbg_out_if: valid/ready channel carrying one gamma-encoded RGB word.
// Depends on rgbg_pkg.
`default_nettype none

interface rgbg_out_if;
  logic                         valid;
  logic                         ready;
  logic [rgbg_pkg::SampleW-1:0] red_out;
  logic [rgbg_pkg::SampleW-1:0] green_out;
  logic [rgbg_pkg::SampleW-1:0] blue_out;

  modport source (output valid, output red_out, output green_out, output blue_out, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out, output ready);
endinterface

`default_nettype wire

// ----- sv/rgbg_chan.sv -----
// rgbg_chan: 17-stage datapath encoding one sample: clamp, toe, and
// 2^(e*p) * (1+t)^p via tables, binomial series and split multipliers.
// Depends on rgbg_pkg.
`default_nettype none

module rgbg_chan (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  rgbg_pkg::cfg_t               cfg_i,
  input  logic [rgbg_pkg::SampleW-1:0] sample_i,
  output logic [rgbg_pkg::SampleW-1:0] code_o
);
  import rgbg_pkg::*;

  logic [SampleW-1:0] kraw_q, k_q;
  logic [ExpW-1:0]    e_d, e_q;
  logic [SampleW-1:0] kn_d;
  logic [7:0]         j_q;
  logic [6:0]         w_q;
  logic [36:0]        toe_prod;
  logic [11:0]        toe_q  [3:16];
  logic               tsel_q [3:16];

  logic [47:0]        ef_v, mt_v;
  logic [56:0]        u_prod;
  logic [55:0]        u_q    [4:9];
  logic [47:0]        app_q  [4];
  logic [2:0]         ip_q   [4:15];

  logic [95:0]        a_sum;
  logic [53:0]        a_q    [5:12];

  logic signed [66:0] h5_p, h4_p, h3_p, h2_p, h1_p;
  logic signed [33:0] t5_q, t4_q, t3_q, t2_q;
  logic signed [49:0] s_full;
  logic [47:0]        s_q;

  logic [47:0]        ud_v;
  logic [47:0]        dpp_q  [4];
  logic [95:0]        d_sum;
  logic [47:0]        d_q;

  logic [47:0]        at_v;
  logic [47:0]        adpp_q [4];
  logic [95:0]        ad_sum;
  logic [53:0]        y_q;

  logic [50:0]        fypp_q [2];
  logic [77:0]        z_q;
  logic [84:0]        zs_v, cs_v;
  logic [17:0]        code_d, code_q;

  logic [17:0]        sel_v, lo_v;
  logic [SampleW-1:0] out_d, out_q;

  // leading one and normalized mantissa
  always_comb begin
    e_d = '0;
    for (int b = 0; b < SampleW; b++) begin
      if (k_q[b]) e_d = ExpW'(b);
    end
    kn_d = k_q << (ExpW'(SampleW - 1) - e_d);
  end

  assign toe_prod = k_q[7:0] * ToeMul;

  assign ef_v   = EfTab[e_q];
  assign mt_v   = MantTab[j_q];
  assign u_prod = w_q * RcpTab[j_q];

  assign a_sum = (96'(app_q[0]) << 48) + (96'(app_q[1]) << 24)
               + (96'(app_q[2]) << 24) + 96'(app_q[3]);

  // Horner on u in Q0.40, terms in Q1.32
  assign h5_p = $signed({1'b0, u_q[4][55:24]}) * CoefB6;
  assign h4_p = $signed({1'b0, u_q[5][55:24]}) * t5_q;
  assign h3_p = $signed({1'b0, u_q[6][55:24]}) * t4_q;
  assign h2_p = $signed({1'b0, u_q[7][55:24]}) * t3_q;
  assign h1_p = $signed({1'b0, u_q[8][55:24]}) * t2_q;
  assign s_full = $signed({2'b00, CoefB1}) + 50'(h1_p >>> 24);

  assign ud_v  = u_q[9][55:8];
  assign d_sum = (96'(dpp_q[0]) << 48) + (96'(dpp_q[1]) << 24)
               + (96'(dpp_q[2]) << 24) + 96'(dpp_q[3]);

  assign at_v   = a_q[11][53:6];
  assign ad_sum = (96'(adpp_q[0]) << 48) + (96'(adpp_q[1]) << 24)
                + (96'(adpp_q[2]) << 24) + 96'(adpp_q[3]);

  assign zs_v   = 85'(z_q) << ip_q[15];
  assign cs_v   = 85'(ConNum) << 54;
  assign code_d = (zs_v > cs_v) ? 18'((zs_v - cs_v) >> 66) : '0;

  always_comb begin
    sel_v = tsel_q[16] ? 18'(toe_q[16]) : code_q;
    lo_v  = (sel_v < 18'(cfg_i.black_level)) ? 18'(cfg_i.black_level) : sel_v;
    out_d = (lo_v > 18'(cfg_i.white_point)) ? cfg_i.white_point : lo_v[SampleW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kraw_q <= sample_i;
      k_q    <= (kraw_q > cfg_i.white_point) ? cfg_i.white_point : kraw_q;

      e_q       <= e_d;
      j_q       <= kn_d[14:7];
      w_q       <= kn_d[6:0];
      toe_q[3]  <= toe_prod[36:25];
      tsel_q[3] <= (k_q < ToeLimit);

      u_q[4]   <= u_prod[55:0];
      app_q[0] <= ef_v[47:24] * mt_v[47:24];
      app_q[1] <= ef_v[47:24] * mt_v[23:0];
      app_q[2] <= ef_v[23:0] * mt_v[47:24];
      app_q[3] <= ef_v[23:0] * mt_v[23:0];
      ip_q[4]  <= EiTab[e_q];

      a_q[5] <= a_sum[95:42];
      t5_q   <= CoefB5 + 34'(h5_p >>> 40);
      t4_q   <= CoefB4 + 34'(h4_p >>> 40);
      t3_q   <= CoefB3 + 34'(h3_p >>> 40);
      t2_q   <= CoefB2 + 34'(h2_p >>> 40);
      s_q    <= s_full[47:0];

      dpp_q[0] <= ud_v[47:24] * s_q[47:24];
      dpp_q[1] <= ud_v[47:24] * s_q[23:0];
      dpp_q[2] <= ud_v[23:0] * s_q[47:24];
      dpp_q[3] <= ud_v[23:0] * s_q[23:0];
      d_q      <= d_sum[95:48];

      adpp_q[0] <= at_v[47:24] * d_q[47:24];
      adpp_q[1] <= at_v[47:24] * d_q[23:0];
      adpp_q[2] <= at_v[23:0] * d_q[47:24];
      adpp_q[3] <= at_v[23:0] * d_q[23:0];
      y_q       <= a_q[12] + 54'(ad_sum[95:50]);

      fypp_q[0] <= FacNum * y_q[53:27];
      fypp_q[1] <= FacNum * y_q[26:0];
      z_q       <= (78'(fypp_q[0]) << 27) + 78'(fypp_q[1]);
      code_q    <= code_d;
      out_q     <= out_d;

      for (int s = 4; s <= 16; s++) begin
        toe_q[s]  <= toe_q[s-1];
        tsel_q[s] <= tsel_q[s-1];
      end
      for (int s = 5; s <= 15; s++) begin
        ip_q[s] <= ip_q[s-1];
      end
      for (int s = 5; s <= 9; s++) begin
        u_q[s] <= u_q[s-1];
      end
      for (int s = 6; s <= 12; s++) begin
        a_q[s] <= a_q[s-1];
      end
    end
  end

  assign code_o = out_q;

endmodule

`default_nettype wire

// ----- sv/rgb16_gamma_encode_core.sv -----
// Pixel gamma encoder: one RGB word in, one encoded RGB word out. Depends on
// rgbg_pkg, rgbg_in_if, rgbg_out_if and rgbg_chan.
//
// Takes one pixel per clock while the output is not stalled. Each sample is clamped to the white point,
// encoded as 12.92*k below 200 and as 680.552897*k^0.416667 - 3604.425
// from 200 up (truncated), then clipped to black level .. white point. The
// three channels run in parallel through a 17-stage pipeline; the last stage
// is the output register. A stall on the output freezes the whole pipeline,
// so input ready follows output ready while the output word is valid.
// Configuration writes take effect at once and must only happen while the
// pipeline is empty. No start-up sweep after reset.
`default_nettype none

module rgb16_gamma_encode_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  rgbg_in_if.sink                      in_if,
  rgbg_out_if.source                   out_if,
  input  logic                         cfg_we_i,
  input  logic [rgbg_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rgbg_pkg::SampleW-1:0] cfg_data_i
);
  import rgbg_pkg::*;

  logic [SampleW-1:0] wp_q, bl_q;
  logic [NumStg-1:0]  vld_q;
  logic               en;
  cfg_t               cfg;

  assign cfg.white_point = wp_q;
  assign cfg.black_level = bl_q;

  assign en           = !vld_q[NumStg-1] || out_if.ready;
  assign in_if.ready  = en;
  assign out_if.valid = vld_q[NumStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '1;
      bl_q  <= '0;
      vld_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgWhitePoint: begin
            wp_q <= cfg_data_i;
          end
          CfgBlackLevel: begin
            bl_q <= cfg_data_i;
          end
          default: begin
          end
        endcase
      end
      if (en) begin
        vld_q <= {vld_q[NumStg-2:0], in_if.valid};
      end
    end
  end

  rgbg_chan u_red (
    .clk_i    (clk_i),
    .en_i     (en),
    .cfg_i    (cfg),
    .sample_i (in_if.red_in),
    .code_o   (out_if.red_out)
  );

  rgbg_chan u_green (
    .clk_i    (clk_i),
    .en_i     (en),
    .cfg_i    (cfg),
    .sample_i (in_if.green_in),
    .code_o   (out_if.green_out)
  );

  rgbg_chan u_blue (
    .clk_i    (clk_i),
    .en_i     (en),
    .cfg_i    (cfg),
    .sample_i (in_if.blue_in),
    .code_o   (out_if.blue_out)
  );

endmodule

`default_nettype wire
